// ===== sv/bcc_pkg.sv =====
package bcc_pkg;

    // field and register widths
    localparam int FLAG_W     = 6;
    localparam int PERIOD_W   = 8;
    localparam int TICKS_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W    = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_TICKS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_TICKS  = 2'd2;

    // register reset values
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 8'd20;
    localparam logic [TICKS_W-1:0]  LONG_TICKS_RST    = 16'd2000;
    localparam logic [TICKS_W-1:0]  DOUBLE_TICKS_RST  = 16'd200;

    // item kinds
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // event flag bits
    localparam logic [FLAG_W-1:0] FLAG_HOLD   = 6'h01;
    localparam logic [FLAG_W-1:0] FLAG_DOWN   = 6'h02;
    localparam logic [FLAG_W-1:0] FLAG_UP     = 6'h04;
    localparam logic [FLAG_W-1:0] FLAG_SINGLE = 6'h08;
    localparam logic [FLAG_W-1:0] FLAG_DOUBLE = 6'h10;
    localparam logic [FLAG_W-1:0] FLAG_LONG   = 6'h20;

    typedef struct packed {
        logic              mode;
        logic              pin_level;
        logic [FLAG_W-1:0] flag_mask;
    } item_t;

    typedef struct packed {
        logic              flag_hit;
        logic [FLAG_W-1:0] flags_now;
    } result_t;

endpackage

// ===== sv/bcc_core.sv =====
module bcc_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              step_en,
    input  bcc_pkg::item_t                    item,
    output bcc_pkg::result_t                  result
);
    import bcc_pkg::*;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SECOND = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LONG   = 3'd4;

    logic [PERIOD_W-1:0] sample_period_reg;
    logic [TICKS_W-1:0]  long_ticks_reg;
    logic [TICKS_W-1:0]  double_ticks_reg;

    logic [PERIOD_W-1:0] sample_count_reg, sample_count_next;
    logic                now_pressed_reg, now_pressed_next;
    logic                last_pressed_reg, last_pressed_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [TICKS_W-1:0]  timer_reg, timer_next;
    logic [FLAG_W-1:0]   flags_reg, flags_next;
    logic [PERIOD_W-1:0] count_inc;
    logic                hit;

    assign count_inc = sample_count_reg + {{(PERIOD_W-1){1'b0}}, 1'b1};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RST;
            long_ticks_reg    <= LONG_TICKS_RST;
            double_ticks_reg  <= DOUBLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LONG_TICKS:    long_ticks_reg    <= cfg_data[TICKS_W-1:0];
                CFG_DOUBLE_TICKS:  double_ticks_reg  <= cfg_data[TICKS_W-1:0];
                default:           ;
            endcase
        end
    end

    // tick and query update
    always_comb
    begin
        sample_count_next = sample_count_reg;
        now_pressed_next  = now_pressed_reg;
        last_pressed_next = last_pressed_reg;
        phase_next        = phase_reg;
        timer_next        = timer_reg;
        flags_next        = flags_reg;
        hit               = 1'b0;

        if (item.mode == MODE_TICK)
        begin
            // timer counts down and stops at zero
            timer_next        = (timer_reg != '0) ? timer_reg - 16'd1 : '0;
            sample_count_next = count_inc;
            if (count_inc >= sample_period_reg)
            begin
                sample_count_next = '0;
                last_pressed_next = now_pressed_reg;
                now_pressed_next  = ~item.pin_level;
                // press and release edges
                if (now_pressed_next && !now_pressed_reg)
                    flags_next = flags_next | FLAG_DOWN;
                if (!now_pressed_next && now_pressed_reg)
                    flags_next = flags_next | FLAG_UP;
                // click classifier
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (now_pressed_next)
                        begin
                            flags_next = flags_next | FLAG_HOLD;
                            timer_next = long_ticks_reg;
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST:
                    begin
                        if (!now_pressed_next)
                        begin
                            flags_next = flags_next & ~FLAG_HOLD;
                            timer_next = double_ticks_reg;
                            phase_next = PH_WAIT;
                        end
                        else if (timer_next == '0)
                        begin
                            flags_next = flags_next | FLAG_LONG;
                            phase_next = PH_LONG;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (now_pressed_next)
                        begin
                            flags_next = flags_next | FLAG_DOUBLE;
                            phase_next = PH_SECOND;
                        end
                        else if (timer_next == '0)
                        begin
                            flags_next = flags_next | FLAG_SINGLE;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_SECOND:
                    begin
                        if (!now_pressed_next)
                            phase_next = PH_IDLE;
                    end
                    PH_LONG:
                    begin
                        if (!now_pressed_next)
                        begin
                            flags_next = flags_next & ~FLAG_HOLD;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            // query: test masked flags, clear them unless hold alone
            hit = |(flags_reg & item.flag_mask);
            if (hit && (item.flag_mask != FLAG_HOLD))
                flags_next = flags_reg & ~item.flag_mask;
        end

        result.flag_hit  = hit;
        result.flags_now = flags_next;
    end

    // classifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            now_pressed_reg  <= 1'b0;
            last_pressed_reg <= 1'b0;
            phase_reg        <= PH_IDLE;
            timer_reg        <= '0;
            flags_reg        <= '0;
        end
        else if (step_en)
        begin
            sample_count_reg <= sample_count_next;
            now_pressed_reg  <= now_pressed_next;
            last_pressed_reg <= last_pressed_next;
            phase_reg        <= phase_next;
            timer_reg        <= timer_next;
            flags_reg        <= flags_next;
        end
    end

endmodule

// ===== sv/button_click_classifier.sv =====
// button click classifier: debounced single, double and long press flags, plus hold, down and up
// path: input register holds the accepted word, result register holds its result on m_axis
// throughput: one word per cycle while m_axis drains; stalls on m_axis_tready low
// reset: asynchronous active low; clears flags, phase, timer and pipeline valids,
// and loads the default sample period, long and double windows
module button_click_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // pin_level, flag_mask[5:0], pad
    input  logic                           s_axis_tuser,  // mode
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata   // flag_hit, flags_now[5:0], pad
);
    import bcc_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t core_result;
    logic    step;
    logic    s_fire;

    // handshake
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.mode      <= s_axis_tuser;
            in_item_reg.pin_level <= s_axis_tdata[0];
            in_item_reg.flag_mask <= s_axis_tdata[FLAG_W:1];
        end
    end

    bcc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .step_en  (step),
        .item     (in_item_reg),
        .result   (core_result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg.flags_now, out_data_reg.flag_hit};

endmodule
